// File: rtl/rv32es_pkg.sv
// Package for the RV32I-subset execute step: operation codes, widths,
// write-port records and small helpers. Depends on nothing.
package rv32es_pkg;

   localparam int unsigned XLen       = 32;
   localparam int unsigned RegCount   = 32;
   localparam int unsigned RegAw      = 5;
   localparam int unsigned MemAw      = 10;              // data memory is a power of two
   localparam int unsigned MemWords   = 1 << MemAw;
   localparam int unsigned WordIdxW   = 10;              // width of the reported word index
   localparam int unsigned LuiShift   = 12;
   localparam logic [7:0]  ByteMask   = 8'hFF;

   typedef logic [XLen-1:0] word_type;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,
      OP_SUB  = 5'd1,
      OP_AND  = 5'd2,
      OP_OR   = 5'd3,
      OP_XOR  = 5'd4,
      OP_NOR  = 5'd5,
      OP_SLT  = 5'd6,
      OP_SLL  = 5'd7,
      OP_SRA  = 5'd8,
      OP_ADDI = 5'd9,
      OP_ANDI = 5'd10,
      OP_ORI  = 5'd11,
      OP_XORI = 5'd12,
      OP_SLTI = 5'd13,
      OP_LW   = 5'd14,
      OP_LB   = 5'd15,
      OP_SW   = 5'd16,
      OP_SB   = 5'd17,
      OP_LUI  = 5'd18
   } op_type;

   // Register file write, as committed or in flight.
   typedef struct packed {
      logic             valid;
      logic [RegAw-1:0] index;
      word_type         value;
   } reg_wr_type;

   // Data memory word write.
   typedef struct packed {
      logic             valid;
      logic [MemAw-1:0] index;
      word_type         value;
   } mem_wr_type;

   function automatic logic signed_less(input word_type a, input word_type b);
      return $signed(a) < $signed(b);
   endfunction

endpackage

// File: rtl/rv32es_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on rv32es_pkg for widths.
interface rv32es_req_if;
   logic                         valid;
   logic                         ready;
   logic [4:0]                   action;
   logic [rv32es_pkg::RegAw-1:0] dest_index;
   logic [rv32es_pkg::RegAw-1:0] src1_index;
   logic [rv32es_pkg::RegAw-1:0] src2_index;
   logic signed [31:0]           immediate;

   modport source (output valid, action, dest_index, src1_index, src2_index, immediate,
                   input ready);
   modport sink   (input valid, action, dest_index, src1_index, src2_index, immediate,
                   output ready);
endinterface

interface rv32es_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            reg_write;
   logic [rv32es_pkg::RegAw-1:0]    written_index;
   logic signed [31:0]              written_value;
   logic                            mem_write;
   logic [rv32es_pkg::WordIdxW-1:0] mem_word_index;
   logic [31:0]                     mem_word_value;

   modport source (output valid, reg_write, written_index, written_value, mem_write,
                   mem_word_index, mem_word_value, input ready);
   modport sink   (input valid, reg_write, written_index, written_value, mem_write,
                   mem_word_index, mem_word_value, output ready);
endinterface

// File: rtl/rv32_subset_execute_step_top.sv
// Top level of the RV32I-subset execute step: register file, data memory,
// forwarding and result register. Depends on rv32es_pkg, rv32es_if,
// rv32es_ram and rv32es_alu.
//
// Usage:
//   req_chan carries one decoded instruction per item (action, register
//   indices, immediate); rsp_chan returns exactly one result item per
//   instruction, in order, describing the register write and memory store.
//   Throughput: one item per cycle while the memory clear is not running
//   and the pipeline is not frozen. The register file is read at accept,
//   the ALU and address add run in the next cycle, the data memory read
//   and commit in the one after; results of the two younger in-flight
//   writes are forwarded, so back-to-back dependent items never stall.
//   Reset: the register file comes up as zero through per-entry valid bits.
//   The data memory is cleared by a pass over all MemWords (1024) words
//   after reset releases; req_chan.ready stays low during that pass.
//   Receiver stall: while a result waits in the output register and the
//   commit stage holds an item, the whole pipeline freezes; bubbles ahead
//   of the commit stage still fill, so input is taken while a result waits.
module rv32_subset_execute_step_top (
   input logic             clock,
   input logic             reset,
   rv32es_req_if.sink      req_chan,
   rv32es_rsp_if.source    rsp_chan
);

   localparam int unsigned AW = rv32es_pkg::MemAw;
   localparam int unsigned RW = rv32es_pkg::RegAw;

   // ---------------------------------------------------------------- control
   logic                  advance;
   logic                  accept;
   logic                  clear_busy_ff, clear_busy_in;
   logic [AW-1:0]         clear_addr_ff, clear_addr_in;

   // ---------------------------------------------------------------- stage 1
   logic                  s1_valid_ff, s1_valid_in;
   rv32es_pkg::op_type    s1_op_ff;
   logic [RW-1:0]         s1_rd_ff;
   logic [RW-1:0]         s1_ra_ff;
   logic [RW-1:0]         s1_rb_ff;
   rv32es_pkg::word_type  s1_imm_ff;

   // ---------------------------------------------------------------- stage 2
   logic                  s2_valid_ff, s2_valid_in;
   rv32es_pkg::op_type    s2_op_ff;
   logic [RW-1:0]         s2_rd_ff;
   logic                  s2_wr_reg_ff;
   rv32es_pkg::word_type  s2_alu_ff;
   logic [AW-1:0]         s2_widx_ff;
   logic [1:0]            s2_lane_ff;
   rv32es_pkg::word_type  s2_store_ff;

   // ---------------------------------------------------------------- commit
   rv32es_pkg::reg_wr_type rf_commit_ff, rf_commit_in;
   rv32es_pkg::mem_wr_type dm_commit_ff, dm_commit_in;
   logic [rv32es_pkg::RegCount-1:0] rf_valid_ff, rf_valid_in;

   // ---------------------------------------------------------------- output
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_reg_write_ff;
   logic [RW-1:0]         rsp_written_index_ff;
   rv32es_pkg::word_type  rsp_written_value_ff;
   logic                  rsp_mem_write_ff;
   logic [rv32es_pkg::WordIdxW-1:0] rsp_mem_word_index_ff;
   rv32es_pkg::word_type  rsp_mem_word_value_ff;

   // ---------------------------------------------------------------- datapath
   rv32es_pkg::op_type    req_op;
   logic                  req_is_store;
   logic [RW-1:0]         req_rb;
   rv32es_pkg::word_type  rf_a_rdata, rf_b_rdata, dm_rdata;
   rv32es_pkg::word_type  s1_a, s1_b, s1_addr, s1_alu_value;
   logic                  s1_alu_writes;
   logic                  s1_wr_reg;
   rv32es_pkg::word_type  s2_word, s2_load_byte, s2_reg_value, s2_mem_value;
   logic                  s2_is_store;
   rv32es_pkg::reg_wr_type s2_reg_wr;
   logic                  load_out;
   logic                  dm_wr_en;
   logic [AW-1:0]         dm_wr_addr;
   rv32es_pkg::word_type  dm_wr_data;
   logic [31:0]           s2_widx_ext;

   // Resolve a register read: x0, then the youngest in-flight write, then the
   // last committed write, then the RAM word if the entry was ever written.
   function automatic rv32es_pkg::word_type resolve(
      input logic [RW-1:0]           idx,
      input rv32es_pkg::word_type    ram_data,
      input rv32es_pkg::reg_wr_type  young,
      input rv32es_pkg::reg_wr_type  old,
      input logic [rv32es_pkg::RegCount-1:0] vbits
   );
      rv32es_pkg::word_type r;
      if (idx == '0) begin
         r = '0;
      end else if (young.valid && young.index == idx) begin
         r = young.value;
      end else if (old.valid && old.index == idx) begin
         r = old.value;
      end else if (vbits[idx]) begin
         r = ram_data;
      end else begin
         r = '0;
      end
      return r;
   endfunction

   // Freeze only when the commit stage has an item and the output slot is stuck.
   assign advance  = !(rsp_valid_ff && !rsp_chan.ready && s2_valid_ff);
   assign req_chan.ready = advance && !clear_busy_ff && !reset;
   assign accept   = req_chan.valid && req_chan.ready;
   assign load_out = advance && s2_valid_ff;

   // Stores read the data register on the second port instead of src2.
   assign req_op       = rv32es_pkg::op_type'(req_chan.action);
   assign req_is_store = req_op inside {rv32es_pkg::OP_SW, rv32es_pkg::OP_SB};
   assign req_rb       = req_is_store ? req_chan.dest_index : req_chan.src2_index;

   // Two copies of the register file, written together, one read port each.
   rv32es_ram #(.Width(rv32es_pkg::XLen), .Depth(rv32es_pkg::RegCount)) u_rf_a (
      .clock   (clock),
      .wr_en   (load_out && s2_reg_wr.valid),
      .wr_addr (s2_reg_wr.index),
      .wr_data (s2_reg_wr.value),
      .rd_en   (advance),
      .rd_addr (req_chan.src1_index),
      .rd_data (rf_a_rdata)
   );

   rv32es_ram #(.Width(rv32es_pkg::XLen), .Depth(rv32es_pkg::RegCount)) u_rf_b (
      .clock   (clock),
      .wr_en   (load_out && s2_reg_wr.valid),
      .wr_addr (s2_reg_wr.index),
      .wr_data (s2_reg_wr.value),
      .rd_en   (advance),
      .rd_addr (req_rb),
      .rd_data (rf_b_rdata)
   );

   // ---------------------------------------------------------------- stage 1 logic
   always_comb begin
      s1_a = resolve(s1_ra_ff, rf_a_rdata, s2_reg_wr, rf_commit_ff, rf_valid_ff);
      s1_b = resolve(s1_rb_ff, rf_b_rdata, s2_reg_wr, rf_commit_ff, rf_valid_ff);
      s1_addr = s1_a + s1_imm_ff;
   end

   rv32es_alu u_alu (
      .op         (s1_op_ff),
      .src_a      (s1_a),
      .src_b      (s1_b),
      .imm        (s1_imm_ff),
      .value      (s1_alu_value),
      .writes_reg (s1_alu_writes)
   );

   assign s1_wr_reg = s1_alu_writes && (s1_rd_ff != '0);

   rv32es_ram #(.Width(rv32es_pkg::XLen), .Depth(rv32es_pkg::MemWords)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_wr_en),
      .wr_addr (dm_wr_addr),
      .wr_data (dm_wr_data),
      .rd_en   (advance),
      .rd_addr (s1_addr[AW+1:2]),
      .rd_data (dm_rdata)
   );

   // ---------------------------------------------------------------- stage 2 logic
   always_comb begin
      // The store committed with this item's memory read was missed by the RAM.
      if (dm_commit_ff.valid && dm_commit_ff.index == s2_widx_ff) begin
         s2_word = dm_commit_ff.value;
      end else begin
         s2_word = dm_rdata;
      end

      case (s2_lane_ff)
         2'd0:    s2_load_byte = {{24{s2_word[7]}},  s2_word[7:0]};
         2'd1:    s2_load_byte = {{24{s2_word[15]}}, s2_word[15:8]};
         2'd2:    s2_load_byte = {{24{s2_word[23]}}, s2_word[23:16]};
         default: s2_load_byte = {{24{s2_word[31]}}, s2_word[31:24]};
      endcase

      case (s2_op_ff)
         rv32es_pkg::OP_LW: s2_reg_value = s2_word;
         rv32es_pkg::OP_LB: s2_reg_value = s2_load_byte;
         default:           s2_reg_value = s2_alu_ff;
      endcase

      s2_is_store = s2_op_ff inside {rv32es_pkg::OP_SW, rv32es_pkg::OP_SB};
      s2_mem_value = '0;
      if (s2_op_ff == rv32es_pkg::OP_SW) begin
         s2_mem_value = s2_store_ff;
      end else if (s2_op_ff == rv32es_pkg::OP_SB) begin
         // Merge the low byte of the data register into one lane.
         s2_mem_value = s2_word;
         case (s2_lane_ff)
            2'd0:    s2_mem_value[7:0]   = s2_store_ff[7:0] & rv32es_pkg::ByteMask;
            2'd1:    s2_mem_value[15:8]  = s2_store_ff[7:0] & rv32es_pkg::ByteMask;
            2'd2:    s2_mem_value[23:16] = s2_store_ff[7:0] & rv32es_pkg::ByteMask;
            default: s2_mem_value[31:24] = s2_store_ff[7:0] & rv32es_pkg::ByteMask;
         endcase
      end

      s2_reg_wr.valid = s2_valid_ff && s2_wr_reg_ff;
      s2_reg_wr.index = s2_rd_ff;
      s2_reg_wr.value = s2_reg_value;

      s2_widx_ext = 32'(s2_widx_ff);
   end

   // Data memory write port: clearing pass first, then store commits.
   always_comb begin
      if (clear_busy_ff) begin
         dm_wr_en   = 1'b1;
         dm_wr_addr = clear_addr_ff;
         dm_wr_data = '0;
      end else begin
         dm_wr_en   = load_out && s2_is_store;
         dm_wr_addr = s2_widx_ff;
         dm_wr_data = s2_mem_value;
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + AW'(1);
         if (clear_addr_ff == AW'(rv32es_pkg::MemWords - 1)) begin
            clear_busy_in = 1'b0;
         end
      end

      s1_valid_in  = advance ? accept : s1_valid_ff;
      s2_valid_in  = advance ? s1_valid_ff : s2_valid_ff;

      rf_commit_in = rf_commit_ff;
      dm_commit_in = dm_commit_ff;
      rf_valid_in  = rf_valid_ff;
      if (advance) begin
         rf_commit_in       = s2_reg_wr;
         dm_commit_in.valid = s2_valid_ff && s2_is_store;
         dm_commit_in.index = s2_widx_ff;
         dm_commit_in.value = s2_mem_value;
         if (s2_reg_wr.valid) begin
            rf_valid_in[s2_reg_wr.index] = 1'b1;
         end
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rf_valid_ff   <= '0;
         rf_commit_ff  <= '0;
         dm_commit_ff  <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rf_valid_ff   <= rf_valid_in;
         rf_commit_ff  <= rf_commit_in;
         dm_commit_ff  <= dm_commit_in;
      end
   end

   // Payload: advance all stages together; hold while frozen.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff     <= req_op;
         s1_rd_ff     <= req_chan.dest_index;
         s1_ra_ff     <= req_chan.src1_index;
         s1_rb_ff     <= req_rb;
         s1_imm_ff    <= $unsigned(req_chan.immediate);

         s2_op_ff     <= s1_op_ff;
         s2_rd_ff     <= s1_rd_ff;
         s2_wr_reg_ff <= s1_wr_reg;
         s2_alu_ff    <= s1_alu_value;
         s2_widx_ff   <= s1_addr[AW+1:2];
         s2_lane_ff   <= s1_addr[1:0];
         s2_store_ff  <= s1_b;
      end
      if (load_out) begin
         rsp_reg_write_ff      <= s2_wr_reg_ff;
         rsp_written_index_ff  <= s2_wr_reg_ff ? s2_rd_ff : '0;
         rsp_written_value_ff  <= s2_wr_reg_ff ? s2_reg_value : '0;
         rsp_mem_write_ff      <= s2_is_store;
         rsp_mem_word_index_ff <= s2_is_store ? s2_widx_ext[rv32es_pkg::WordIdxW-1:0] : '0;
         rsp_mem_word_value_ff <= s2_is_store ? s2_mem_value : '0;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.reg_write      = rsp_reg_write_ff;
   assign rsp_chan.written_index  = rsp_written_index_ff;
   assign rsp_chan.written_value  = $signed(rsp_written_value_ff);
   assign rsp_chan.mem_write      = rsp_mem_write_ff;
   assign rsp_chan.mem_word_index = rsp_mem_word_index_ff;
   assign rsp_chan.mem_word_value = rsp_mem_word_value_ff;

`ifndef NO_ASSERTIONS
   // x0 must never be marked as written.
   a_x0_never_valid: assert property (@(posedge clock) disable iff (reset)
      !rf_valid_ff[0])
      else $error("register x0 marked as written");

   // A frozen commit stage keeps its item.
   a_s2_held: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !advance) |=> s2_valid_ff)
      else $error("commit-stage item lost while frozen");

   // A reported register write never names x0.
   a_rsp_no_x0: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_reg_write_ff) |-> (rsp_written_index_ff != '0))
      else $error("result reports a write to x0");

   // The clearing pass owns the memory write port alone.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("item in flight during memory clear");
`endif

endmodule

// File: rtl/rv32es_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module rv32es_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 32,
   localparam int unsigned AddrW = $clog2(Depth)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rv32es_alu.sv
// Register/immediate ALU of the execute step: arithmetic, logic, compare,
// shifts and upper immediate. Depends on rv32es_pkg.
module rv32es_alu (
   input  rv32es_pkg::op_type   op,
   input  rv32es_pkg::word_type src_a,
   input  rv32es_pkg::word_type src_b,
   input  rv32es_pkg::word_type imm,
   output rv32es_pkg::word_type value,
   output logic                 writes_reg
);

   always_comb begin
      value      = '0;
      writes_reg = 1'b1;
      case (op)
         rv32es_pkg::OP_ADD:  value = src_a + src_b;
         rv32es_pkg::OP_SUB:  value = src_a - src_b;
         rv32es_pkg::OP_AND:  value = src_a & src_b;
         rv32es_pkg::OP_OR:   value = src_a | src_b;
         rv32es_pkg::OP_XOR:  value = src_a ^ src_b;
         rv32es_pkg::OP_NOR:  value = ~(src_a | src_b);
         rv32es_pkg::OP_SLT:  value = 32'(rv32es_pkg::signed_less(src_a, src_b));
         rv32es_pkg::OP_SLL:  value = src_a << src_b[4:0];
         rv32es_pkg::OP_SRA:  value = $unsigned($signed(src_a) >>> src_b[4:0]);
         rv32es_pkg::OP_ADDI: value = src_a + imm;
         rv32es_pkg::OP_ANDI: value = src_a & imm;
         rv32es_pkg::OP_ORI:  value = src_a | imm;
         rv32es_pkg::OP_XORI: value = src_a ^ imm;
         rv32es_pkg::OP_SLTI: value = 32'(rv32es_pkg::signed_less(src_a, imm));
         rv32es_pkg::OP_LUI:  value = imm << rv32es_pkg::LuiShift;
         // loads produce their value after the memory read
         rv32es_pkg::OP_LW, rv32es_pkg::OP_LB: value = '0;
         default:             writes_reg = 1'b0;
      endcase
   end

endmodule

// File: verif/rv32_subset_execute_step_top_tb.sv
// Testbench for rv32_subset_execute_step_top: streams decoded instructions, keeps its own
// copy of the register file and data memory, and checks every result item in order.
// Depends on rv32es_pkg, rv32es_if and the RTL of the block.
`timescale 1ns / 100ps

module rv32_subset_execute_step_top_tb;

   localparam int unsigned ItemCount   = 1350;
   localparam int unsigned QuietTail   = 150;    // items left when idling stops
   localparam int unsigned MaxReports  = 10;
   localparam int unsigned DrainCycles = 8;      // pipeline depth plus margin
   localparam int unsigned IdleMin     = 1;
   localparam int unsigned IdleMax     = 18;
   localparam int unsigned IdlePct     = 5;
   localparam logic [4:0]  ActUnusedLow  = 5'd19;
   localparam logic [4:0]  ActUnusedHigh = 5'd31;
   localparam rv32es_pkg::word_type MinInt  = 32'h8000_0000;
   localparam rv32es_pkg::word_type MaxInt  = 32'h7FFF_FFFF;
   localparam rv32es_pkg::word_type AllOnes = 32'hFFFF_FFFF;

   // One decoded instruction as driven on req_chan.
   typedef struct packed {
      logic [4:0]                   action;
      logic [rv32es_pkg::RegAw-1:0] rd;
      logic [rv32es_pkg::RegAw-1:0] rs1;
      logic [rv32es_pkg::RegAw-1:0] rs2;
      rv32es_pkg::word_type         imm;
   } instr_type;

   // Architectural effect of one instruction, as reported on rsp_chan.
   typedef struct packed {
      logic                            reg_write;
      logic [rv32es_pkg::RegAw-1:0]    written_index;
      rv32es_pkg::word_type            written_value;
      logic                            mem_write;
      logic [rv32es_pkg::WordIdxW-1:0] mem_word_index;
      rv32es_pkg::word_type            mem_word_value;
   } effect_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rv32es_req_if req_chan();
   rv32es_rsp_if rsp_chan();

   rv32_subset_execute_step_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   // Architectural state, advanced once per accepted item.
   rv32es_pkg::word_type arch_regs [rv32es_pkg::RegCount] = '{default: '0};
   rv32es_pkg::word_type arch_mem  [rv32es_pkg::MemWords] = '{default: '0};

   instr_type  instr_queue[$];        // items not yet presented
   effect_type expected_effects[$];   // predicted results, oldest first
   int unsigned mismatch_count = 0;
   int unsigned send_idle = 0;
   int unsigned recv_stall = 0;

   function automatic rv32es_pkg::word_type read_reg(logic [rv32es_pkg::RegAw-1:0] idx);
      return (idx == '0) ? '0 : arch_regs[idx];
   endfunction

   // Execute one instruction on the architectural copy and return its effect.
   function automatic effect_type retire_instr(instr_type ins);
      rv32es_pkg::word_type         a, b, addr, val, mval, word, store_src;
      logic [rv32es_pkg::MemAw-1:0] widx;
      logic [4:0]                   lane_bit;
      logic [7:0]                   byte_val;
      logic                         wr_reg, wr_mem;
      effect_type                   eff;
      a        = read_reg(ins.rs1);
      b        = read_reg(ins.rs2);
      addr     = a + ins.imm;
      widx     = addr[rv32es_pkg::MemAw+1:2];   // word index wraps to the memory size
      lane_bit = {addr[1:0], 3'b000};
      word     = arch_mem[widx];
      store_src = read_reg(ins.rd);
      val      = '0;
      mval     = '0;
      wr_reg   = 1'b1;
      wr_mem   = 1'b0;
      case (ins.action)
         rv32es_pkg::OP_ADD:  val = a + b;
         rv32es_pkg::OP_SUB:  val = a - b;
         rv32es_pkg::OP_AND:  val = a & b;
         rv32es_pkg::OP_OR:   val = a | b;
         rv32es_pkg::OP_XOR:  val = a ^ b;
         rv32es_pkg::OP_NOR:  val = ~(a | b);
         rv32es_pkg::OP_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
         rv32es_pkg::OP_SLL:  val = a << b[4:0];
         rv32es_pkg::OP_SRA:  val = $signed(a) >>> b[4:0];
         rv32es_pkg::OP_ADDI: val = a + ins.imm;
         rv32es_pkg::OP_ANDI: val = a & ins.imm;
         rv32es_pkg::OP_ORI:  val = a | ins.imm;
         rv32es_pkg::OP_XORI: val = a ^ ins.imm;
         rv32es_pkg::OP_SLTI: val = ($signed(a) < $signed(ins.imm)) ? 32'd1 : 32'd0;
         rv32es_pkg::OP_LW:   val = word;
         rv32es_pkg::OP_LB: begin
            byte_val = word[lane_bit +: 8];
            val      = {{24{byte_val[7]}}, byte_val};
         end
         rv32es_pkg::OP_SW: begin
            wr_reg = 1'b0;
            wr_mem = 1'b1;
            mval   = store_src;
         end
         rv32es_pkg::OP_SB: begin
            wr_reg = 1'b0;
            wr_mem = 1'b1;
            mval   = word;
            mval[lane_bit +: 8] = store_src[7:0];
         end
         rv32es_pkg::OP_LUI:  val = ins.imm << rv32es_pkg::LuiShift;
         default: wr_reg = 1'b0;
      endcase
      eff = '0;
      if (wr_reg && ins.rd != '0) begin
         arch_regs[ins.rd]  = val;
         eff.reg_write      = 1'b1;
         eff.written_index  = ins.rd;
         eff.written_value  = val;
      end
      if (wr_mem) begin
         arch_mem[widx]     = mval;
         eff.mem_write      = 1'b1;
         eff.mem_word_index = widx;
         eff.mem_word_value = mval;
      end
      return eff;
   endfunction

   function automatic string show_effect(effect_type e);
      return $sformatf("reg_write=%0b idx=%0d val=%h mem_write=%0b widx=%0d wval=%h",
                       e.reg_write, e.written_index, e.written_value,
                       e.mem_write, e.mem_word_index, e.mem_word_value);
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MaxReports)
         $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic push_instr(logic [4:0] act, logic [rv32es_pkg::RegAw-1:0] rd,
                             logic [rv32es_pkg::RegAw-1:0] rs1,
                             logic [rv32es_pkg::RegAw-1:0] rs2,
                             rv32es_pkg::word_type imm);
      instr_queue.push_back(instr_type'{act, rd, rs1, rs2, imm});
   endtask

   // Bias register indices toward a small set so results feed later items
   // back to back and exercise forwarding.
   function automatic logic [rv32es_pkg::RegAw-1:0] pick_reg();
      int unsigned r;
      r = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 7) : $urandom_range(0, 31);
      return r[rv32es_pkg::RegAw-1:0];
   endfunction

   function automatic rv32es_pkg::word_type pick_imm();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return rv32es_pkg::word_type'($signed($urandom_range(0, 63)) - 32);
         4, 5, 6:    return $urandom();
         7: begin
            case ($urandom_range(0, 3))
               0:       return MinInt;
               1:       return MaxInt;
               2:       return AllOnes;
               default: return '0;
            endcase
         end
         default:    return $urandom_range(0, 4095);
      endcase
   endfunction

   function automatic instr_type random_instr();
      instr_type   ins;
      int unsigned pct;
      pct     = $urandom_range(0, 99);
      ins.rd  = pick_reg();
      ins.rs1 = pick_reg();
      ins.rs2 = pick_reg();
      ins.imm = pick_imm();
      if (pct < 3) begin
         ins.action = 5'($urandom_range(ActUnusedLow, ActUnusedHigh));
      end else if (pct < 35) begin
         ins.action = 5'($urandom_range(rv32es_pkg::OP_LW, rv32es_pkg::OP_SB));
         // Mostly hit a small window so loads see earlier stores.
         if ($urandom_range(0, 99) < 70) begin
            ins.rs1 = '0;
            ins.imm = $urandom_range(0, 127);
         end
      end else if (pct < 45) begin
         ins.action = ($urandom_range(0, 1) != 0) ? rv32es_pkg::OP_LUI : rv32es_pkg::OP_ADDI;
      end else begin
         ins.action = 5'($urandom_range(rv32es_pkg::OP_ADD, rv32es_pkg::OP_LUI));
      end
      return ins;
   endfunction

   // Driver: present the next item once the current one is taken; idle in
   // random bursts except in the tail of the run.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid      <= 1'b0;
         req_chan.action     <= '0;
         req_chan.dest_index <= '0;
         req_chan.src1_index <= '0;
         req_chan.src2_index <= '0;
         req_chan.immediate  <= '0;
         send_idle = 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (send_idle > 0) begin
            send_idle--;
            req_chan.valid <= 1'b0;
         end else if (instr_queue.size() > 0) begin
            req_chan.valid      <= 1'b1;
            req_chan.action     <= instr_queue[0].action;
            req_chan.dest_index <= instr_queue[0].rd;
            req_chan.src1_index <= instr_queue[0].rs1;
            req_chan.src2_index <= instr_queue[0].rs2;
            req_chan.immediate  <= instr_queue[0].imm;
            void'(instr_queue.pop_front());
            if (instr_queue.size() > QuietTail && $urandom_range(0, 99) < IdlePct)
               send_idle = $urandom_range(IdleMin, IdleMax);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Predict on acceptance, in acceptance order.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         expected_effects.push_back(retire_instr(instr_type'{req_chan.action,
                                                    req_chan.dest_index,
                                                    req_chan.src1_index, req_chan.src2_index,
                                                    req_chan.immediate}));
   end

   // Receiver: stall in random bursts and check each accepted result against
   // the oldest prediction.
   always @(posedge clock) begin
      effect_type seen;
      effect_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen = '{rsp_chan.reg_write, rsp_chan.written_index, rsp_chan.written_value,
                     rsp_chan.mem_write, rsp_chan.mem_word_index, rsp_chan.mem_word_value};
            if (expected_effects.size() == 0) begin
               report_mismatch({"result with nothing pending: ", show_effect(seen)});
            end else begin
               want = expected_effects.pop_front();
               if (seen !== want)
                  report_mismatch({"expected ", show_effect(want),
                                   " got ", show_effect(seen)});
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (instr_queue.size() > QuietTail && $urandom_range(0, 99) < IdlePct)
               recv_stall = $urandom_range(IdleMin, IdleMax);
         end
      end
   end

   initial begin
      // Directed: build extreme operands, then every operation on them.
      push_instr(rv32es_pkg::OP_LUI,  5'd1,  5'd0, 5'd0, 32'h0008_0000); // x1 = min int
      push_instr(rv32es_pkg::OP_ADDI, 5'd2,  5'd0, 5'd0, AllOnes);       // x2 = -1
      push_instr(rv32es_pkg::OP_ADDI, 5'd3,  5'd0, 5'd0, MaxInt);        // x3 = max int
      push_instr(rv32es_pkg::OP_ADDI, 5'd4,  5'd0, 5'd0, MinInt);
      push_instr(rv32es_pkg::OP_ADD,  5'd5,  5'd1, 5'd2, '0);
      push_instr(rv32es_pkg::OP_SUB,  5'd6,  5'd1, 5'd3, '0);
      push_instr(rv32es_pkg::OP_AND,  5'd7,  5'd2, 5'd3, '0);
      push_instr(rv32es_pkg::OP_OR,   5'd8,  5'd1, 5'd3, '0);
      push_instr(rv32es_pkg::OP_XOR,  5'd9,  5'd2, 5'd1, '0);            // x9 = max int
      push_instr(rv32es_pkg::OP_NOR,  5'd10, 5'd0, 5'd0, '0);
      push_instr(rv32es_pkg::OP_SLT,  5'd11, 5'd1, 5'd3, '0);
      push_instr(rv32es_pkg::OP_SLL,  5'd12, 5'd2, 5'd2, '0);            // shift by 31
      push_instr(rv32es_pkg::OP_SRA,  5'd13, 5'd1, 5'd2, '0);
      push_instr(rv32es_pkg::OP_ANDI, 5'd14, 5'd2, 5'd0, MinInt);
      push_instr(rv32es_pkg::OP_ORI,  5'd15, 5'd0, 5'd0, AllOnes);
      push_instr(rv32es_pkg::OP_XORI, 5'd16, 5'd3, 5'd0, AllOnes);
      push_instr(rv32es_pkg::OP_SLTI, 5'd17, 5'd3, 5'd0, MinInt);
      // Memory: word store, byte merge into the top lane, signed byte loads.
      push_instr(rv32es_pkg::OP_SW,   5'd9,  5'd0, 5'd0, '0);
      push_instr(rv32es_pkg::OP_SB,   5'd1,  5'd0, 5'd0, 32'd3);
      push_instr(rv32es_pkg::OP_LB,   5'd18, 5'd0, 5'd0, 32'd2);
      push_instr(rv32es_pkg::OP_LW,   5'd19, 5'd0, 5'd0, '0);
      // Store of x0 data at the top word, reached by a negative offset.
      push_instr(rv32es_pkg::OP_SW,   5'd0,  5'd0, 5'd0, 32'hFFFF_FFFC);
      // Byte store whose word index wraps past the memory size.
      push_instr(rv32es_pkg::OP_SB,   5'd3,  5'd0, 5'd0, 32'h0000_1005);
      push_instr(rv32es_pkg::OP_LB,   5'd20, 5'd0, 5'd0, 32'd5);
      push_instr(rv32es_pkg::OP_ADD,  5'd0,  5'd1, 5'd2, '0);            // write to x0 dropped
      push_instr(ActUnusedLow,  5'd21, 5'd1, 5'd2, AllOnes);
      push_instr(ActUnusedHigh, 5'd22, 5'd3, 5'd4, AllOnes);
      push_instr(rv32es_pkg::OP_LUI,  5'd23, 5'd0, 5'd0, AllOnes);

      repeat (ItemCount) instr_queue.push_back(random_instr());

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Hold until every item is taken, then drain the results.
      while (instr_queue.size() != 0 || req_chan.valid) @(posedge clock);
      while (expected_effects.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Allow for the memory clear after reset and every item meeting the longest
   // idle on both sides, with a wide margin.
   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: files.f
rtl/rv32es_pkg.sv
rtl/rv32es_if.sv
rtl/rv32es_ram.sv
rtl/rv32es_alu.sv
rtl/rv32_subset_execute_step_top.sv
verif/rv32_subset_execute_step_top_tb.sv
